// ===== design/tzut_pkg.sv =====
package tzut_pkg;

  localparam int unsigned VAR_W    = 10;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned END_W    = 11;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [ACT_W-1:0] ACT_LOAD        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MARK        = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RESTORE_DEC = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RESTORE_DEF = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESTORE_UNC = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ        = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ASSIGNED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DECISION_ZONE_END = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFINED_ZONE_END  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIABLE_TOTAL    = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_MK_POS,
    ST_MK_ORD,
    ST_MK_FIN
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [END_W-1:0] pos;
  } pos_entry_t;

endpackage

// ===== design/three_zone_unassigned_tracker.sv =====
// Sparse-set tracker with three zones (decision, defined, unconstrained), each with its own
// unassigned end. Requests arrive one at a time on the slave stream; each gives one result.
// After reset the position memory is swept to "eliminated", one entry per cycle over all
// MAX_VARIABLES entries, and no request is taken until the sweep ends (configuration writes
// are taken at any time). Load, restore, unused-action and out-of-range mark requests are
// answered from idle; a slot read waits in ST_RD_WAIT for its order memory read. A mark reads
// the position memory and issues its result from ST_MK_POS, where a mark that finds its
// variable eliminated or already assigned ends; one that moves it reads both order entries
// there and does two write-backs, in ST_MK_ORD and ST_MK_FIN, as each memory has a single
// write port. The next request is taken once they finish and the output register is free.
module three_zone_unassigned_tracker #(
  parameter int unsigned MAX_VARIABLES = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tzut_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tzut_pkg::END_W-1:0]           cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // action[2:0], variable[12:3], slot[22:13], new_end[33:23], zero pad
  input  logic [tzut_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // slot_variable[9:0], decision_end_now[20:10], defined_end_now[31:21],
  // unconstrained_end_now[42:32], status[44:43], zero pad
  output logic [tzut_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned AW = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VARIABLES - 1);
  localparam logic [tzut_pkg::END_W-1:0] END_MAX = tzut_pkg::END_W'(MAX_VARIABLES);

  // configuration
  logic [tzut_pkg::END_W-1:0] dec_zone_q, def_zone_q, var_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_zone_q  <= '0;
      def_zone_q  <= '0;
      var_total_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tzut_pkg::CFG_DECISION_ZONE_END: dec_zone_q  <= cfg_wdata_i;
        tzut_pkg::CFG_DEFINED_ZONE_END:  def_zone_q  <= cfg_wdata_i;
        tzut_pkg::CFG_VARIABLE_TOTAL:    var_total_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request fields
  logic [tzut_pkg::ACT_W-1:0]  in_act;
  logic [tzut_pkg::VAR_W-1:0]  in_var;
  logic [tzut_pkg::SLOT_W-1:0] in_slot;
  logic [tzut_pkg::END_W-1:0]  in_end;

  assign in_act  = s_axis_tdata_i[2:0];
  assign in_var  = s_axis_tdata_i[12:3];
  assign in_slot = s_axis_tdata_i[22:13];
  assign in_end  = s_axis_tdata_i[33:23];

  // memories
  tzut_pkg::pos_entry_t pos_mem [MAX_VARIABLES];
  logic [tzut_pkg::VAR_W-1:0] ord_mem [MAX_VARIABLES];

  logic                       pos_we;
  logic [AW-1:0]              pos_wa, pos_ra;
  tzut_pkg::pos_entry_t       pos_wd, pos_rd_q;
  logic                       ord_we;
  logic [AW-1:0]              ord_wa, ord_ra0, ord_ra1;
  logic [tzut_pkg::VAR_W-1:0] ord_wd, ord_rd0_q, ord_rd1_q;

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    ord_rd0_q <= ord_mem[ord_ra0];
    ord_rd1_q <= ord_mem[ord_ra1];
  end

  // control and state
  tzut_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [tzut_pkg::END_W-1:0] dec_end_q, dec_end_d, def_end_q, def_end_d;
  logic [tzut_pkg::END_W-1:0] unc_end_q, unc_end_d;
  logic                          m_valid_q, m_valid_d;
  logic [tzut_pkg::VAR_W-1:0]    slot_var_q, slot_var_d;
  logic [tzut_pkg::STATUS_W-1:0] status_q, status_d;
  logic [tzut_pkg::END_W-1:0]    pos_q, pos_d, last_q, last_d;
  logic [tzut_pkg::VAR_W-1:0]    a_q, a_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tzut_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      dec_end_q <= '0;
      def_end_q <= '0;
      unc_end_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      dec_end_q <= dec_end_d;
      def_end_q <= def_end_d;
      unc_end_q <= unc_end_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_var_q <= slot_var_d;
    status_q   <= status_d;
    pos_q      <= pos_d;
    last_q     <= last_d;
    a_q        <= a_d;
  end

  logic                       in_fire;
  logic [tzut_pkg::END_W-1:0] total_eff, end_sel, rst_end;
  logic [1:0]                 zone;

  assign s_axis_tready_o = (state_q == tzut_pkg::ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign total_eff       = (32'(var_total_q) > MAX_VARIABLES) ? END_MAX : var_total_q;
  assign rst_end         = (32'(in_end) > MAX_VARIABLES) ? END_MAX : in_end;

  always_comb begin
    if (pos_rd_q.pos < dec_zone_q) begin
      zone    = 2'd0;
      end_sel = dec_end_q;
    end else if (pos_rd_q.pos < def_zone_q) begin
      zone    = 2'd1;
      end_sel = def_end_q;
    end else begin
      zone    = 2'd2;
      end_sel = unc_end_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    dec_end_d  = dec_end_q;
    def_end_d  = def_end_q;
    unc_end_d  = unc_end_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    slot_var_d = slot_var_q;
    status_d   = status_q;
    pos_d      = pos_q;
    last_d     = last_q;
    a_d        = a_q;

    pos_we  = 1'b0;
    pos_wa  = AW'(in_var);
    pos_wd  = '{valid: 1'b1, pos: tzut_pkg::END_W'(in_slot)};
    pos_ra  = AW'(in_var);
    ord_we  = 1'b0;
    ord_wa  = AW'(in_slot);
    ord_wd  = in_var;
    ord_ra0 = AW'(in_slot);
    ord_ra1 = AW'(last_q);

    case (state_q)
      tzut_pkg::ST_CLEAR: begin
        pos_we    = 1'b1;
        pos_wa    = clr_cnt_q;
        pos_wd    = '{valid: 1'b0, pos: '0};
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_IDX) begin
          state_d = tzut_pkg::ST_IDLE;
        end
      end
      tzut_pkg::ST_IDLE: begin
        if (in_fire) begin
          m_valid_d  = 1'b1;
          slot_var_d = '0;
          status_d   = tzut_pkg::STATUS_DONE;
          case (in_act)
            tzut_pkg::ACT_LOAD: begin
              if (32'(in_var) >= MAX_VARIABLES || 32'(in_slot) >= MAX_VARIABLES) begin
                status_d = tzut_pkg::STATUS_IGNORED;
              end else begin
                pos_we = 1'b1;
                ord_we = 1'b1;
              end
            end
            tzut_pkg::ACT_MARK: begin
              if (tzut_pkg::END_W'(in_var) >= total_eff) begin
                status_d = tzut_pkg::STATUS_IGNORED;
              end else begin
                m_valid_d = 1'b0;
                state_d   = tzut_pkg::ST_MK_POS;
              end
            end
            tzut_pkg::ACT_RESTORE_DEC: dec_end_d = rst_end;
            tzut_pkg::ACT_RESTORE_DEF: def_end_d = rst_end;
            tzut_pkg::ACT_RESTORE_UNC: unc_end_d = rst_end;
            tzut_pkg::ACT_READ: begin
              if (32'(in_slot) >= MAX_VARIABLES) begin
                status_d = tzut_pkg::STATUS_IGNORED;
              end else begin
                m_valid_d = 1'b0;
                state_d   = tzut_pkg::ST_RD_WAIT;
              end
            end
            default: status_d = tzut_pkg::STATUS_IGNORED;
          endcase
        end
      end
      tzut_pkg::ST_RD_WAIT: begin
        m_valid_d  = 1'b1;
        slot_var_d = ord_rd0_q;
        status_d   = tzut_pkg::STATUS_DONE;
        state_d    = tzut_pkg::ST_IDLE;
      end
      tzut_pkg::ST_MK_POS: begin
        m_valid_d  = 1'b1;
        slot_var_d = '0;
        pos_d      = pos_rd_q.pos;
        last_d     = end_sel - 1'b1;
        ord_ra0    = AW'(pos_rd_q.pos);
        ord_ra1    = AW'(end_sel - 1'b1);
        state_d    = tzut_pkg::ST_IDLE;
        if (!pos_rd_q.valid) begin
          status_d = tzut_pkg::STATUS_IGNORED;
        end else if (pos_rd_q.pos >= end_sel || 32'(pos_rd_q.pos) >= MAX_VARIABLES) begin
          status_d = tzut_pkg::STATUS_ASSIGNED;
        end else begin
          status_d = tzut_pkg::STATUS_DONE;
          state_d  = tzut_pkg::ST_MK_ORD;
          case (zone)
            2'd0:    dec_end_d = end_sel - 1'b1;
            2'd1:    def_end_d = end_sel - 1'b1;
            default: unc_end_d = end_sel - 1'b1;
          endcase
        end
      end
      tzut_pkg::ST_MK_ORD: begin
        // rd0 = entry at pos, rd1 = entry at last
        a_d    = ord_rd0_q;
        ord_we = 1'b1;
        ord_wa = AW'(pos_q);
        ord_wd = ord_rd1_q;
        pos_we = 32'(ord_rd1_q) < MAX_VARIABLES;
        pos_wa = AW'(ord_rd1_q);
        pos_wd = '{valid: 1'b1, pos: pos_q};
        state_d = tzut_pkg::ST_MK_FIN;
      end
      tzut_pkg::ST_MK_FIN: begin
        ord_we = 1'b1;
        ord_wa = AW'(last_q);
        ord_wd = a_q;
        pos_we = 32'(a_q) < MAX_VARIABLES;
        pos_wa = AW'(a_q);
        pos_wd = '{valid: 1'b1, pos: last_q};
        state_d = tzut_pkg::ST_IDLE;
      end
      default: state_d = tzut_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, status_q, unc_end_q, def_end_q, dec_end_q, slot_var_q};

endmodule
